### sv/sstb_pkg.sv
// ----------------------------------------------------------------------------
// sstb_pkg: shared types and constants of the seven-segment frame builder
// Action codes, display command bytes, segment table, digit weights and the
// command record that travels from the front end to the byte sequencer.
// ----------------------------------------------------------------------------
package sstb_pkg;

  // number of digits on the display
  localparam int DIGIT_COUNT = 4;

  // decimal digits needed for a 16-bit number
  localparam int NUM_DEC_DIGITS = 5;

  // digit steps run on the whole number, leading ones are dropped
  localparam int TOTAL_STEPS = (DIGIT_COUNT > NUM_DEC_DIGITS) ? DIGIT_COUNT : NUM_DEC_DIGITS;
  localparam int DROP_STEPS  = TOTAL_STEPS - DIGIT_COUNT;

  // slots of one show command: two header bytes, then digits
  localparam int PRE_SLOTS  = (DROP_STEPS > 2) ? DROP_STEPS : 2;
  localparam int STEP_OFS   = PRE_SLOTS - DROP_STEPS;
  localparam int SHOW_SLOTS = PRE_SLOTS + DIGIT_COUNT;
  localparam int SLOT_W     = $clog2(SHOW_SLOTS);
  localparam int STEP_W     = $clog2(TOTAL_STEPS);

  // tracker and mask width
  localparam int DOT_W = 4;

  // weight width, large enough for nine times the top weight
  localparam int WT_W = 24;

  // action codes
  localparam logic [1:0] ACT_SHOW   = 2'd0;
  localparam logic [1:0] ACT_COLON  = 2'd1;
  localparam logic [1:0] ACT_DOT    = 2'd2;
  localparam logic [1:0] ACT_BRIGHT = 2'd3;

  // command bytes
  localparam logic [7:0] CMD_DATA     = 8'h40;
  localparam logic [7:0] CMD_ADDR0    = 8'hC0;
  localparam logic [7:0] CMD_DISP_OFF = 8'h80;
  localparam logic [7:0] CMD_DISP_ON  = 8'h88;
  localparam logic [3:0] COLON_BIT    = 4'h2;
  localparam logic [7:0] DOT_SEG      = 8'h80;
  localparam logic [3:0] BRIGHT_MAX   = 4'd8;

  typedef logic [WT_W-1:0] wt_t;
  typedef wt_t wt_arr_t [TOTAL_STEPS];

  // command record from front end to sequencer
  typedef struct packed {
    logic             bright;
    logic [15:0]      number;
    logic [DOT_W-1:0] dots;
    logic [7:0]       bright_byte;
  } cmd_t;

  // weight of each digit step, most significant first
  function automatic wt_arr_t build_weights();
    wt_arr_t     w;
    int unsigned p;
    for (int i = TOTAL_STEPS - 1; i >= 0; i--) begin
      if (i == TOTAL_STEPS - 1) begin
        p = 1;
      end else begin
        p = p * 10;
      end
      w[i] = wt_t'(p);
    end
    return w;
  endfunction

  localparam wt_arr_t WEIGHTS = build_weights();

  // segment pattern of one decimal digit
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

### sv/sstb_front.sv
// ----------------------------------------------------------------------------
// sstb_front: action decoder and dot tracker
// Accepts action items, keeps the dot tracker, drops ignored dot requests and
// turns the rest into command records for the byte sequencer.
// ----------------------------------------------------------------------------
module sstb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [1:0]          action,
  input  logic [15:0]         number,
  input  logic [3:0]          dot_mask,
  input  logic [2:0]          dot_pos,
  input  logic                status,
  input  logic [3:0]          brightness,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output sstb_pkg::cmd_t      cmd
);

  logic [sstb_pkg::DOT_W-1:0] dot_tracker_r;
  logic [sstb_pkg::DOT_W-1:0] dot_tracker_nxt;
  logic [sstb_pkg::DOT_W-1:0] dot_sel;
  logic [3:0]                 bright_sat;
  logic                       take;
  logic                       ignored;

  // the queue slot must be free for every item, ignored ones included
  assign item_ready = cmd_ready;
  assign take       = item_valid && item_ready;
  assign ignored    = (action == sstb_pkg::ACT_DOT) && dot_pos[2];

  // dot tracker update
  always_comb begin
    dot_tracker_nxt = dot_tracker_r;
    dot_sel         = 4'b0001 << dot_pos[1:0];
    unique case (action)
      sstb_pkg::ACT_COLON: begin
        if (status) begin
          dot_tracker_nxt = dot_tracker_r | sstb_pkg::COLON_BIT;
        end else begin
          dot_tracker_nxt = dot_tracker_r & ~sstb_pkg::COLON_BIT;
        end
      end
      sstb_pkg::ACT_DOT: begin
        if (!dot_pos[2]) begin
          if (status) begin
            dot_tracker_nxt = dot_tracker_r | dot_sel;
          end else begin
            dot_tracker_nxt = dot_tracker_r & ~dot_sel;
          end
        end
      end
      default: dot_tracker_nxt = dot_tracker_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_tracker_r <= '0;
    end else if (take) begin
      dot_tracker_r <= dot_tracker_nxt;
    end
  end

  // brightness byte with saturation
  assign bright_sat = (brightness > sstb_pkg::BRIGHT_MAX) ? sstb_pkg::BRIGHT_MAX : brightness;

  // command record
  always_comb begin
    cmd.bright = (action == sstb_pkg::ACT_BRIGHT);
    cmd.number = number;
    cmd.dots   = (action == sstb_pkg::ACT_SHOW) ? dot_mask : dot_tracker_nxt;
    if (bright_sat == 4'd0) begin
      cmd.bright_byte = sstb_pkg::CMD_DISP_OFF;
    end else begin
      cmd.bright_byte = sstb_pkg::CMD_DISP_ON | {5'd0, 3'(bright_sat - 4'd1)};
    end
  end

  assign cmd_valid = item_valid && !ignored;

endmodule

### sv/sstb_queue.sv
// ----------------------------------------------------------------------------
// sstb_queue: two-entry command queue
// Decouples the decoder from the byte sequencer so each side stalls alone.
// ----------------------------------------------------------------------------
module sstb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  sstb_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sstb_pkg::cmd_t pop_data
);

  sstb_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/sstb_back.sv
// ----------------------------------------------------------------------------
// sstb_back: byte sequencer
// Walks one command a slot per cycle while the output is not stalled: one
// brightness byte, or header bytes and one decimal digit step per slot from
// slot 1 on (compare against multiples of the weight, subtract); drives the registered output stage.
// ----------------------------------------------------------------------------
module sstb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  sstb_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_start,
  output logic           out_stop,
  output logic           out_last
);

  sstb_pkg::cmd_t                cmd_r;
  logic                          active_r;
  logic [sstb_pkg::SLOT_W-1:0]   slot_r;
  logic [15:0]                   rem_r;
  logic [15:0]                   rem_nxt;
  logic                          out_valid_r;
  logic [7:0]                    out_byte_r;
  logic                          out_start_r;
  logic                          out_stop_r;
  logic                          out_last_r;

  logic                          adv;
  logic                          work;
  logic                          at_end;
  logic                          fin;
  logic                          take;
  logic                          step_ok;
  logic [sstb_pkg::STEP_W-1:0]   widx;
  logic [sstb_pkg::STEP_W-1:0]   pos;
  logic                          show_digit;
  logic                          dot_on;
  logic                          emit;
  sstb_pkg::wt_t                 wt;
  sstb_pkg::wt_t                 sub;
  logic [3:0]                    digit;
  logic [7:0]                    byte_val;
  logic                          start_val;
  logic                          stop_val;
  logic                          last_val;

  // slot control
  assign adv     = !out_valid_r || out_ready;
  assign work    = active_r && adv;
  assign at_end  = cmd_r.bright || (slot_r == sstb_pkg::SLOT_W'(sstb_pkg::SHOW_SLOTS - 1));
  assign fin     = work && at_end;
  assign take    = cmd_valid && (!active_r || fin);
  assign cmd_ready = !active_r || fin;

  // digit step position
  assign step_ok    = (slot_r >= sstb_pkg::SLOT_W'(sstb_pkg::STEP_OFS));
  assign widx       = sstb_pkg::STEP_W'(slot_r - sstb_pkg::SLOT_W'(sstb_pkg::STEP_OFS));
  assign show_digit = step_ok && (widx >= sstb_pkg::STEP_W'(sstb_pkg::DROP_STEPS));
  assign pos        = widx - sstb_pkg::STEP_W'(sstb_pkg::DROP_STEPS);
  assign dot_on     = (pos < sstb_pkg::STEP_W'(sstb_pkg::DOT_W)) && cmd_r.dots[pos[1:0]];

  // one decimal digit: parallel compares against k times the weight
  always_comb begin
    wt    = sstb_pkg::WEIGHTS[widx];
    digit = 4'd0;
    sub   = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({{(sstb_pkg::WT_W-16){1'b0}}, rem_r} >= sstb_pkg::WT_W'(wt * sstb_pkg::WT_W'(k))) begin
        digit = 4'(k);
        sub   = sstb_pkg::WT_W'(wt * sstb_pkg::WT_W'(k));
      end
    end
    rem_nxt = 16'({{(sstb_pkg::WT_W-16){1'b0}}, rem_r} - sub);
  end

  // byte of the current slot
  always_comb begin
    byte_val  = sstb_pkg::seg_of(digit) | (dot_on ? sstb_pkg::DOT_SEG : 8'h00);
    start_val = 1'b0;
    stop_val  = at_end;
    last_val  = at_end;
    emit      = show_digit;
    if (cmd_r.bright) begin
      byte_val  = cmd_r.bright_byte;
      start_val = 1'b1;
      stop_val  = 1'b1;
      last_val  = 1'b1;
      emit      = 1'b1;
    end else if (slot_r == sstb_pkg::SLOT_W'(0)) begin
      byte_val  = sstb_pkg::CMD_DATA;
      start_val = 1'b1;
      stop_val  = 1'b1;
      last_val  = 1'b0;
      emit      = 1'b1;
    end else if (slot_r == sstb_pkg::SLOT_W'(1)) begin
      byte_val  = sstb_pkg::CMD_ADDR0;
      start_val = 1'b1;
      stop_val  = 1'b0;
      last_val  = 1'b0;
      emit      = 1'b1;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      slot_r   <= '0;
    end else if (take) begin
      active_r <= 1'b1;
      slot_r   <= '0;
    end else if (fin) begin
      active_r <= 1'b0;
    end else if (work) begin
      slot_r <= slot_r + sstb_pkg::SLOT_W'(1);
    end
  end

  // command and remainder
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd;
      rem_r <= cmd.number;
    end else if (work && step_ok) begin
      rem_r <= rem_nxt;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= work && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (work && emit) begin
      out_byte_r  <= byte_val;
      out_start_r <= start_val;
      out_stop_r  <= stop_val;
      out_last_r  <= last_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_start = out_start_r;
  assign out_stop  = out_stop_r;
  assign out_last  = out_last_r;

endmodule

### sv/seven_segment_frame_builder_top.sv
// ----------------------------------------------------------------------------
// seven_segment_frame_builder_top: display command frame builder
// Turns display actions into the byte stream for a four-digit controller.
// ----------------------------------------------------------------------------
// Usage
//   in_* channel takes one action per transaction, the action code in tuser:
//   show a number with a dot mask, set the colon, set a decimal dot, or set
//   the brightness. out_* channel gives one bus byte per transaction with
//   start and stop flags in tuser and tlast on the final byte of an action.
//   A show action gives six bytes (0x40, 0xC0, four digit bytes), brightness
//   gives one byte, a dot request with index above three gives none.
// Throughput
//   An accepted action passes the queue entry, the sequencer's command register
//   and the output register before its first byte appears, later while earlier
//   bytes are still going out. The sequencer emits one byte per cycle while
//   out_tready does not stall it; the digit step (one decimal digit per cycle)
//   runs alongside the byte slots and so adds no slots of its own.
//   A two-entry command queue sits between decoder and sequencer, so new
//   actions are taken while earlier bytes are still going out.
// Reset and stall
//   Reset clears the dot tracker, the queue and the output stage.
//   A low out_tready holds the current byte; the queue then fills and
//   in_tready drops once both entries are taken.
// ----------------------------------------------------------------------------
module seven_segment_frame_builder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // number[15:0], dot_mask[19:16], dot_pos[22:20],
                                  // status[23], brightness[27:24]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // bus_byte[7:0]
  output logic [1:0]  out_tuser,  // frame_start[0], frame_stop[1]
  output logic        out_tlast
);

  logic           q_push_valid;
  logic           q_push_ready;
  sstb_pkg::cmd_t q_push_data;
  logic           q_pop_valid;
  logic           q_pop_ready;
  sstb_pkg::cmd_t q_pop_data;

  // decoder and dot tracker
  sstb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (in_tvalid),
    .item_ready  (in_tready),
    .action      (in_tuser[1:0]),
    .number      (in_tdata[15:0]),
    .dot_mask    (in_tdata[19:16]),
    .dot_pos     (in_tdata[22:20]),
    .status      (in_tdata[23]),
    .brightness  (in_tdata[27:24]),
    .cmd_valid   (q_push_valid),
    .cmd_ready   (q_push_ready),
    .cmd         (q_push_data)
  );

  // command queue
  sstb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  // byte sequencer
  sstb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_pop_valid),
    .cmd_ready (q_pop_ready),
    .cmd       (q_pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_start (out_tuser[0]),
    .out_stop  (out_tuser[1]),
    .out_last  (out_tlast)
  );

endmodule

### sv/sstb_checker.sv
// ----------------------------------------------------------------------------
// sstb_checker: port-level checks of the frame builder
// Watches the result channel for frame structure and handshake rules.
// ----------------------------------------------------------------------------
module sstb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // stalled byte stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped under stall");

  // final byte of an action always closes a frame
  a_last_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[1])
    else $error("tlast without stop");

  // a one-byte frame that is not final is the data command
  a_data_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] && out_tuser[1] && !out_tlast |-> out_tdata == 8'h40)
    else $error("bad data command byte");

  // an opened but unclosed frame starts at address zero
  a_addr_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] && !out_tuser[1] |-> out_tdata == 8'hC0)
    else $error("bad address command byte");

  // a byte offered right after the data command must be the address command
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser[0] && out_tuser[1] && !out_tlast
      |=> !out_tvalid || (out_tuser[0] && !out_tuser[1]))
    else $error("address command missing after data command");

endmodule

bind seven_segment_frame_builder_top sstb_checker u_sstb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
